// ===== design/olrm_pkg.sv =====
`timescale 1ns / 1ps

package olrm_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;
  localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXISTS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_LT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GT = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  // broadcast to every cell; enables are already qualified by the transaction
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    data_t             operand;
    logic [MODE_W-1:0] mode;
    logic              ins_en;
    logic              pop_en;
    logic              rm_en;
  } cell_ctrl_t;

endpackage

// ===== design/olrm_in_if.sv =====
`timescale 1ns / 1ps

interface olrm_in_if;
  import olrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  data_t             operand_value;
  logic [MODE_W-1:0] compare_mode;

  modport source (output valid, command, operand_value, compare_mode, input ready);
  modport sink   (input valid, command, operand_value, compare_mode, output ready);
endinterface

// ===== design/olrm_out_if.sv =====
`timescale 1ns / 1ps

interface olrm_out_if #(
  parameter int CNT_W = olrm_pkg::CNT_W_DEF
);
  import olrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;
  data_t               out_value;
  logic [CNT_W-1:0]    entry_count;
  logic                is_empty;

  modport source (output valid, status, hit, out_value, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, status, hit, out_value, entry_count, is_empty,
                  output ready);
endinterface

// ===== design/olrm_cell.sv =====
`timescale 1ns / 1ps

module olrm_cell (
  input  logic               clk,
  input  olrm_pkg::cell_ctrl_t ctrl,
  input  logic               valid_in,
  input  logic               before_in,
  input  olrm_pkg::data_t    left_value,
  input  olrm_pkg::data_t    right_value,
  output olrm_pkg::data_t    value,
  output logic               match,
  output olrm_pkg::data_t    sel_value
);
  import olrm_pkg::*;

  data_t value_r;
  data_t value_nxt;
  logic  cond;
  logic  take;

  always_comb begin
    case (ctrl.cmd)
      CMD_EXISTS: cond = (value_r == ctrl.operand);
      CMD_REMOVE: begin
        case (ctrl.mode)
          MODE_LT: cond = (value_r < ctrl.operand);
          MODE_EQ: cond = (value_r == ctrl.operand);
          MODE_GT: cond = (value_r > ctrl.operand);
          default: cond = 1'b0;
        endcase
      end
      default:    cond = 1'b0;
    endcase
  end

  assign match     = valid_in & cond;
  assign sel_value = (match & ~before_in) ? value_r : '0;
  // cells from the first match onward pull from the tail side
  assign take      = ctrl.pop_en | (ctrl.rm_en & (before_in | match));

  always_comb begin
    if (ctrl.ins_en) begin
      value_nxt = left_value;
    end else if (take) begin
      value_nxt = right_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== design/ordered_list_with_conditional_remove.sv =====
`timescale 1ns / 1ps
// channel  | direction | payload
// in_ch    | sink      | command, operand_value, compare_mode
// out_ch   | source    | status, hit, out_value, entry_count, is_empty
//
// One transaction per cycle while out_ch does not stall; its result is registered and shown the cycle after acceptance.
// The path is the per-cell 32-bit compare, a log2(DEPTH)-level prefix OR over the
// cells and the one-hot gather of the removed value.
// Reset clears the entry count and the result valid flag; cell contents are not reset.
// in_ch.ready is high while the result register is empty or being taken.

module ordered_list_with_conditional_remove #(
  parameter int DEPTH = olrm_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  olrm_in_if.sink          in_ch,
  olrm_out_if.source       out_ch
);
  import olrm_pkg::*;

  localparam int LVL = $clog2(DEPTH);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                hit_r;
  logic                hit_nxt;
  data_t               value_r;
  data_t               value_nxt;
  logic [CNT_W-1:0]    cnt_out_r;

  logic                fire;
  logic                full;
  logic                empty;
  logic                any_match;
  cell_ctrl_t          ctrl;
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    match_v;
  logic [DEPTH-1:0]    before_v;
  logic [DEPTH-1:0]    pfx [LVL+1];
  data_t               values    [DEPTH];
  data_t               sel_vals  [DEPTH];
  data_t               rm_value;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign fire        = in_ch.valid & in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    ctrl.cmd     = in_ch.command;
    ctrl.operand = in_ch.operand_value;
    ctrl.mode    = in_ch.compare_mode;
    ctrl.ins_en  = fire & (in_ch.command == CMD_INSERT) & ~full;
    ctrl.pop_en  = fire & (in_ch.command == CMD_POP) & ~empty;
    ctrl.rm_en   = fire & (in_ch.command == CMD_REMOVE);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t left_v;
    data_t right_v;

    assign cell_valid[g] = (CNT_W'(g) < count_r);

    if (g == 0) begin : g_head
      assign left_v      = in_ch.operand_value;
      assign before_v[g] = 1'b0;
    end else begin : g_body
      assign left_v      = values[g-1];
      assign before_v[g] = pfx[LVL][g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_v = values[g];
    end else begin : g_inner
      assign right_v = values[g+1];
    end

    olrm_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid_in    (cell_valid[g]),
      .before_in   (before_v[g]),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (values[g]),
      .match       (match_v[g]),
      .sel_value   (sel_vals[g])
    );
  end

  // log-depth inclusive prefix OR of the match flags
  always_comb begin
    pfx[0] = match_v;
    for (int k = 0; k < LVL; k++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << k)) begin
          pfx[k+1][i] = pfx[k][i] | pfx[k][i-(1<<k)];
        end else begin
          pfx[k+1][i] = pfx[k][i];
        end
      end
    end
  end

  always_comb begin
    rm_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rm_value = rm_value | sel_vals[i];
    end
  end

  assign any_match = |match_v;

  always_comb begin
    status_nxt = STATUS_OK;
    hit_nxt    = 1'b0;
    value_nxt  = '0;
    count_nxt  = count_r;
    case (in_ch.command)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          hit_nxt   = 1'b1;
          value_nxt = values[0];
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_EXISTS: begin
        hit_nxt = any_match;
      end
      CMD_REMOVE: begin
        hit_nxt = any_match;
        if (any_match) begin
          value_nxt = rm_value;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      hit_r     <= hit_nxt;
      value_r   <= value_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.out_value   = value_r;
  assign out_ch.entry_count = cnt_out_r;
  assign out_ch.is_empty    = (cnt_out_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.command == CMD_INSERT && !full |=>
      count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the list");

  a_fail_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != STATUS_OK |-> !hit_r && value_r == '0)
    else $error("rejected transaction reports a hit");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && cnt_out_r == count_r)
    else $error("result count differs from list count");

endmodule

// ===== verif/ordered_list_with_conditional_remove_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_with_conditional_remove_tb;
  import olrm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam data_t MAX_VAL = 32'sh7FFF_FFFF;
  localparam data_t MIN_VAL = 32'sh8000_0000;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 950;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 hit;
    data_t                value;
    logic [CNT_W_DEF-1:0] count;
    logic                 empty;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    data_t             operand;
    logic [MODE_W-1:0] mode;
    int                reps;
    bit                typed;
    result_t           want;
  } row_t;

  localparam result_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst_n;

  olrm_in_if in_ch ();
  olrm_out_if #(.CNT_W(CNT_W_DEF)) out_ch ();

  ordered_list_with_conditional_remove u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  // rows with a typed result are checked against it; the others against the list model
  row_t directed_rows [0:24] = '{
    '{CMD_POP,    32'sd0,   MODE_LT,   1,  1'b1, '{STATUS_EMPTY, 1'b0, 32'sd0, 5'd0, 1'b1}},
    '{CMD_EXISTS, 32'sd0,   MODE_EQ,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd0, 1'b1}},
    '{CMD_REMOVE, 32'sd0,   MODE_EQ,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd0, 1'b1}},
    '{CMD_INSERT, MAX_VAL,  MODE_GT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_EXISTS, MAX_VAL,  MODE_NONE, 1,  1'b1, '{STATUS_OK, 1'b1, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, 32'sd0,   MODE_NONE, 1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, MAX_VAL,  MODE_GT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, MAX_VAL,  MODE_EQ,   1,  1'b1, '{STATUS_OK, 1'b1, MAX_VAL, 5'd0, 1'b1}},
    '{CMD_INSERT, MIN_VAL,  MODE_LT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, MIN_VAL,  MODE_LT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, MIN_VAL,  MODE_GT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}},
    '{CMD_REMOVE, 32'sd0,   MODE_LT,   1,  1'b1, '{STATUS_OK, 1'b1, MIN_VAL, 5'd0, 1'b1}},
    '{CMD_INSERT, -32'sd5,  MODE_EQ,   16, 1'b0, NO_CHECK},
    '{CMD_INSERT, MAX_VAL,  MODE_EQ,   1,  1'b1, '{STATUS_FULL, 1'b0, 32'sd0, 5'd16, 1'b0}},
    '{CMD_EXISTS, 32'sd3,   MODE_LT,   1,  1'b0, NO_CHECK},
    '{CMD_EXISTS, -32'sd100, MODE_GT,  1,  1'b0, NO_CHECK},
    '{CMD_REMOVE, 32'sd0,   MODE_LT,   1,  1'b0, NO_CHECK},
    '{CMD_REMOVE, 32'sd5,   MODE_GT,   1,  1'b0, NO_CHECK},
    '{CMD_REMOVE, -32'sd5,  MODE_EQ,   1,  1'b0, NO_CHECK},
    '{CMD_REMOVE, 32'sd0,   MODE_NONE, 1,  1'b0, NO_CHECK},
    '{CMD_INSERT, MIN_VAL,  MODE_LT,   1,  1'b0, NO_CHECK},
    '{CMD_INSERT, -32'sd1,  MODE_NONE, 1,  1'b0, NO_CHECK},
    '{CMD_POP,    32'sd0,   MODE_EQ,   20, 1'b0, NO_CHECK},
    '{CMD_POP,    -32'sd1,  MODE_NONE, 1,  1'b1, '{STATUS_EMPTY, 1'b0, 32'sd0, 5'd0, 1'b1}},
    '{CMD_INSERT, -32'sd1,  MODE_GT,   1,  1'b1, '{STATUS_OK, 1'b0, 32'sd0, 5'd1, 1'b0}}
  };

  data_t   list_model[$];
  result_t pending_results[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  int      tx_quiet = 0;
  int      rx_stall = 0;
  int      rx_phase = 0;
  bit      rx_calm = 1'b0;
  bit      row_typed;
  result_t row_want;

  function automatic result_t apply_to_list(logic [CMD_W-1:0] cmd, data_t operand,
                                            logic [MODE_W-1:0] mode);
    result_t r;
    bit found;
    bit matched;
    r = '0;
    found = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (list_model.size() >= DEPTH_DEF) r.status = STATUS_FULL;
        else list_model.push_front(operand);
      end
      CMD_POP: begin
        if (list_model.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.value = list_model.pop_front();
          r.hit = 1'b1;
        end
      end
      CMD_EXISTS: begin
        foreach (list_model[i]) if (list_model[i] == operand) r.hit = 1'b1;
      end
      default: begin
        for (int i = 0; i < list_model.size() && !found; i++) begin
          case (mode)
            MODE_LT: matched = list_model[i] < operand;
            MODE_EQ: matched = list_model[i] == operand;
            MODE_GT: matched = list_model[i] > operand;
            default: matched = 1'b0;
          endcase
          if (matched) begin
            r.value = list_model[i];
            r.hit = 1'b1;
            list_model.delete(i);
            found = 1'b1;
          end
        end
      end
    endcase
    r.count = CNT_W_DEF'(list_model.size());
    r.empty = (list_model.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // result side, then request side: a result never belongs to a transaction of the same edge
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.hit !== want.hit)
            report_mismatch("hit", out_ch.hit, want.hit);
          if (out_ch.out_value !== want.value)
            report_mismatch("out_value", $signed(out_ch.out_value), $signed(want.value));
          if (out_ch.entry_count !== want.count)
            report_mismatch("entry_count", out_ch.entry_count, want.count);
          if (out_ch.is_empty !== want.empty)
            report_mismatch("is_empty", out_ch.is_empty, want.empty);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_to_list(in_ch.command, in_ch.operand_value, in_ch.compare_mode);
        pending_results.push_back(row_typed ? row_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_calm <= ~rx_calm;
      rx_phase <= $urandom_range(20, 150);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    if (rx_stall != 0) begin
      out_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 35)
        rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input data_t operand,
                              input logic [MODE_W-1:0] mode, input bit typed,
                              input result_t want);
    int gap;
    int roll;
    gap = 0;
    if (tx_quiet > 0) begin
      tx_quiet--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 4) tx_quiet = $urandom_range(20, 80);
      else if (roll < 12) gap = $urandom_range(10, 30);
      else if (roll < 40) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.operand_value <= operand;
    in_ch.compare_mode <= mode;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int insert_pct;
    int roll;
    int pick;
    logic [CMD_W-1:0] cmd;
    data_t operand;
    logic [MODE_W-1:0] mode;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_INSERT;
    in_ch.operand_value <= '0;
    in_ch.compare_mode <= MODE_LT;
    row_typed <= 1'b0;
    row_want <= NO_CHECK;
    insert_pct = 50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_command(directed_rows[r].cmd, directed_rows[r].operand + k,
                     directed_rows[r].mode, directed_rows[r].typed, directed_rows[r].want);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) insert_pct = $urandom_range(15, 85);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        cmd = CMD_INSERT;
      end else begin
        case ($urandom_range(0, 3))
          0: cmd = CMD_POP;
          1: cmd = CMD_EXISTS;
          default: cmd = CMD_REMOVE;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        operand = $urandom_range(0, 16);
        operand = operand - 8;
      end else if (pick < 55 && list_model.size() != 0) begin
        operand = list_model[$urandom_range(0, list_model.size() - 1)];
      end else if (pick < 70) begin
        case ($urandom_range(0, 4))
          0: operand = MAX_VAL;
          1: operand = MIN_VAL;
          2: operand = 32'sd0;
          3: operand = -32'sd1;
          default: operand = 32'sd1;
        endcase
      end else begin
        operand = $urandom;
      end
      if ($urandom_range(0, 9) == 0) mode = MODE_NONE;
      else mode = MODE_W'($urandom_range(0, 2));
      send_command(cmd, operand, mode, 1'b0, NO_CHECK);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/olrm_pkg.sv
design/olrm_in_if.sv
design/olrm_out_if.sv
design/olrm_cell.sv
design/ordered_list_with_conditional_remove.sv
verif/ordered_list_with_conditional_remove_tb.sv
